// ===== src/fudr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudr_pkg
// Shared types, codes and CRC-32 helper for the firmware update receiver.
// ----------------------------------------------------------------------------
package fudr_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 48;
	localparam int unsigned OFFSET_BITS_DEF = 24;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [15:0] FRAME_LIMIT_RST = 16'd16384;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_DATA   = 2'd2,
		MODE_VERIFY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_ACK_OK   = 2'd0,
		EV_ACK_FAIL = 2'd1,
		EV_FLASH    = 2'd2,
		EV_VERIFY   = 2'd3
	} event_t;

	typedef enum logic [0:0] {
		REG_FRAME_LIMIT = 1'b0,
		REG_SEC_MODE    = 1'b1
	} reg_idx_t;

	localparam logic [1:0] SEC_PLAIN = 2'd0;

	// One result item; offset carried at full 32 bits and truncated at the port
	typedef struct packed {
		event_t      ev;
		logic [7:0]  seq;
		logic        status;
		logic [31:0] crc;
		logic [31:0] offset;
		logic [7:0]  data;
		logic        last;
	} result_t;

	// Up to two results per input item
	typedef struct packed {
		logic    has0;
		logic    has1;
		result_t r0;
		result_t r1;
	} bundle_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int i = 0; i < 8; i++) begin
			t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
		end
		return (crc >> 8) ^ t;
	endfunction

endpackage

// ===== src/fudr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudr_front
// Accepts items, tracks session/frame state and CRC, and pushes a result
// bundle into the queue for each item that yields at least one result.
// ----------------------------------------------------------------------------
module fudr_front #(
	parameter int unsigned MAX_PAYLOAD = fudr_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned OFFSET_BITS = fudr_pkg::OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [15:0]           cfg_data,
	input  logic                  in_fire,
	input  logic [1:0]            mode,
	input  logic [7:0]            seq_num,
	input  logic [7:0]            payload_len,
	input  logic [7:0]            data_byte,
	input  logic [31:0]           expected_crc_a,
	input  logic [31:0]           expected_crc_b,
	output logic                  push,
	output fudr_pkg::bundle_t     bundle
);

	logic [15:0]            frame_limit_q;
	logic [1:0]             sec_mode_q;
	logic                   sess_q;
	logic [7:0]             last_seq_q;
	logic [31:0]            crc_q;
	logic [15:0]            frames_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [7:0]             left_q;
	logic                   facc_q;
	logic [7:0]             fseq_q;

	logic                   sess_d, facc_d;
	logic [7:0]             last_seq_d, left_d, fseq_d, next_seq;
	logic [31:0]            crc_d, crc_upd;
	logic [15:0]            frames_d;
	logic [OFFSET_BITS-1:0] offset_d;
	logic                   may_write, end_ok;
	fudr_pkg::result_t      rz;

	assign crc_upd = fudr_pkg::crc_byte(crc_q, data_byte);
	assign next_seq = (last_seq_q == 8'hFF) ? 8'd1 : last_seq_q + 8'd1;
	assign may_write = (frames_q < frame_limit_q) && ({24'd0, payload_len} <= 32'(MAX_PAYLOAD));

	always_comb begin
		rz = '0;
		sess_d = sess_q; last_seq_d = last_seq_q; crc_d = crc_q; frames_d = frames_q;
		offset_d = offset_q; left_d = left_q; facc_d = facc_q; fseq_d = fseq_q;
		end_ok = 1'b0;
		push = 1'b0;
		bundle = '0;
		case (fudr_pkg::mode_t'(mode))
			fudr_pkg::MODE_START: begin
				sess_d = 1'b1; last_seq_d = '0; crc_d = fudr_pkg::CRC_INIT;
				frames_d = '0; offset_d = '0; left_d = '0; facc_d = 1'b0; fseq_d = '0;
				bundle.has0 = 1'b1;
				bundle.r0 = rz;
				bundle.r0.ev = fudr_pkg::EV_ACK_OK;
				bundle.r0.seq = seq_num;
				bundle.r0.crc = fudr_pkg::CRC_INIT;
				bundle.r0.last = 1'b1;
			end
			fudr_pkg::MODE_HEADER: begin
				left_d = '0;
				bundle.r0 = rz;
				bundle.r0.seq = seq_num;
				bundle.r0.crc = crc_q;
				bundle.r0.last = 1'b1;
				if (!sess_q) begin
					bundle.has0 = 1'b1;
					bundle.r0.ev = fudr_pkg::EV_ACK_FAIL;
				end else if (last_seq_q == seq_num) begin
					bundle.has0 = 1'b1;
					bundle.r0.ev = fudr_pkg::EV_ACK_OK;
				end else if (last_seq_q == 8'd0 || next_seq == seq_num) begin
					last_seq_d = seq_num;
					fseq_d = seq_num;
					facc_d = may_write;
					if (payload_len == 8'd0) begin
						bundle.has0 = 1'b1;
						bundle.r0.ev = may_write ? fudr_pkg::EV_ACK_OK : fudr_pkg::EV_ACK_FAIL;
						if (may_write) frames_d = frames_q + 16'd1;
					end else begin
						left_d = payload_len;
					end
				end
			end
			fudr_pkg::MODE_DATA: begin
				if (left_q != 8'd0) begin
					if (sec_mode_q == fudr_pkg::SEC_PLAIN) crc_d = crc_upd;
					left_d = left_q - 8'd1;
					end_ok = (left_q == 8'd1);
					if (facc_q) begin
						bundle.has0 = 1'b1;
						bundle.r0 = rz;
						bundle.r0.ev = fudr_pkg::EV_FLASH;
						bundle.r0.seq = fseq_q;
						bundle.r0.offset = 32'(offset_q);
						bundle.r0.data = data_byte;
						bundle.r0.last = !end_ok;
						offset_d = offset_q + 1'b1;
					end
					if (end_ok) begin
						bundle.has1 = 1'b1;
						bundle.r1 = rz;
						bundle.r1.ev = facc_q ? fudr_pkg::EV_ACK_OK : fudr_pkg::EV_ACK_FAIL;
						bundle.r1.seq = fseq_q;
						bundle.r1.crc = crc_d;
						bundle.r1.last = 1'b1;
						if (facc_q) frames_d = frames_q + 16'd1;
					end
				end
			end
			default: begin
				bundle.has0 = 1'b1;
				bundle.r0 = rz;
				bundle.r0.ev = fudr_pkg::EV_VERIFY;
				bundle.r0.seq = seq_num;
				bundle.r0.crc = crc_q;
				bundle.r0.status = !(sec_mode_q == fudr_pkg::SEC_PLAIN &&
					expected_crc_a == expected_crc_b && expected_crc_a == crc_q);
				bundle.r0.last = 1'b1;
			end
		endcase
		push = in_fire && (bundle.has0 || bundle.has1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= fudr_pkg::FRAME_LIMIT_RST;
			sec_mode_q <= fudr_pkg::SEC_PLAIN;
			sess_q <= 1'b0; last_seq_q <= '0; crc_q <= fudr_pkg::CRC_INIT;
			frames_q <= 16'hFFFF; offset_q <= '0; left_q <= '0;
			facc_q <= 1'b0; fseq_q <= '0;
		end else begin
			if (cfg_we) begin
				if (fudr_pkg::reg_idx_t'(cfg_idx) == fudr_pkg::REG_FRAME_LIMIT)
					frame_limit_q <= cfg_data;
				else
					sec_mode_q <= cfg_data[1:0];
			end
			if (in_fire) begin
				sess_q <= sess_d; last_seq_q <= last_seq_d; crc_q <= crc_d;
				frames_q <= frames_d; offset_q <= offset_d; left_q <= left_d;
				facc_q <= facc_d; fseq_q <= fseq_d;
			end
		end
	end

endmodule

// ===== src/fudr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudr_queue
// Two-entry bundle queue between the front and the output sequencer.
// ----------------------------------------------------------------------------
module fudr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fudr_pkg::bundle_t wdata,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output fudr_pkg::bundle_t rdata
);

	fudr_pkg::bundle_t mem_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/fudr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fudr_back
// Drains bundles one result at a time into an output register.
// ----------------------------------------------------------------------------
module fudr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  fudr_pkg::bundle_t q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output fudr_pkg::result_t res
);

	logic              sec_q;   // first result of a two-result bundle already sent
	logic              load;
	logic              two;
	fudr_pkg::result_t pick;

	assign two = q_data.has0 && q_data.has1;
	assign load = !q_empty && (!out_valid || out_ready);
	assign pick = (q_data.has0 && !sec_q) ? q_data.r0 : q_data.r1;
	assign q_pop = load && (!two || sec_q);

	always_ff @(posedge clk) begin
		if (load) res <= pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0; sec_q <= 1'b0;
		end else begin
			if (load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (load) sec_q <= two && !sec_q;
		end
	end

endmodule

// ===== src/firmware_update_data_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_update_data_receiver
// Each result is written into the 2-entry queue and then loaded into the
// output register before it appears on the outputs.
// Throughput: one item per cycle while in_ready is high; a data byte ending a
// written frame gives two results, drained one per cycle as out_ready allows.
// Reset (arst_n low, asynchronous) closes the session, CRC to all ones,
// registers to their defaults, queue and output empty.
// ----------------------------------------------------------------------------
module firmware_update_data_receiver #(
	parameter int unsigned MAX_PAYLOAD = fudr_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned OFFSET_BITS = fudr_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [7:0]             seq_num,
	input  logic [7:0]             payload_len,
	input  logic [7:0]             data_byte,
	input  logic [31:0]            expected_crc_a,
	input  logic [31:0]            expected_crc_b,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             event_res,
	output logic [7:0]             seq_echo,
	output logic                   status,
	output logic [31:0]            crc_value,
	output logic [OFFSET_BITS-1:0] flash_offset,
	output logic [7:0]             flash_data,
	output logic                   last
);

	logic              in_fire, push, full, empty, pop;
	fudr_pkg::bundle_t wb, rb;
	fudr_pkg::result_t res;

	assign in_ready = !full;
	assign in_fire = in_valid && in_ready;

	fudr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_fire, .mode, .seq_num,
		.payload_len, .data_byte, .expected_crc_a, .expected_crc_b,
		.push, .bundle(wb)
	);

	fudr_queue u_queue (
		.clk, .arst_n, .push, .wdata(wb), .full, .empty, .pop, .rdata(rb)
	);

	fudr_back u_back (
		.clk, .arst_n, .q_empty(empty), .q_data(rb), .q_pop(pop),
		.out_valid, .out_ready, .res
	);

	assign event_res = res.ev;
	assign seq_echo = res.seq;
	assign status = res.status;
	assign crc_value = res.crc;
	assign flash_offset = res.offset[OFFSET_BITS-1:0];
	assign flash_data = res.data;
	assign last = res.last;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_flash_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == fudr_pkg::EV_FLASH && !last |-> crc_value == 32'd0)
		else $error("flash write carries crc");
`endif

endmodule
